// ===== hw/rtl/rabm_pkg.sv =====
`timescale 1ns / 1ps
package rabm_pkg;

  localparam int SLAVE_COUNT = 4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd25000;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_BLOCK = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ACK   = 2'd1;
  localparam logic [1:0] ST_ACK_HIGH = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_WAIT_HI = 3'b010,
    PH_WAIT_LO = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] slave_id;
    logic [7:0] write_data;
    logic       ack_level;
    logic [7:0] bus_in;
  } item_t;

  typedef struct packed {
    logic [3:0] req_lines;
    logic       rw_level;
    logic       bus_drive;
    logic [7:0] bus_out;
    logic       busy_res;
    logic       data_valid;
    logic [7:0] read_byte;
    logic       is_length;
    logic       last;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

// ===== hw/rtl/rabm_in_stage.sv =====
`timescale 1ns / 1ps
module rabm_in_stage
  import rabm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== hw/rtl/rabm_core.sv =====
`timescale 1ns / 1ps
module rabm_core
  import rabm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        step,
  input  item_t       item,
  output result_t     res
);

  logic [15:0] timeout_limit;
  phase_t      phase, phase_next;
  logic [15:0] poll_count, poll_count_next;
  logic [1:0]  active_slave, active_slave_next;
  logic [1:0]  command_kind, command_kind_next;
  logic [7:0]  held_write_byte, held_write_byte_next;
  logic [7:0]  bytes_remaining, bytes_remaining_next;
  logic        length_seen, length_seen_next;
  logic        drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_limit <= cfg_data;
    end
  end

  always_comb begin
    phase_next           = phase;
    poll_count_next      = poll_count;
    active_slave_next    = active_slave;
    command_kind_next    = command_kind;
    held_write_byte_next = held_write_byte;
    bytes_remaining_next = bytes_remaining;
    length_seen_next     = length_seen;
    res                  = '0;
    unique case (phase)
      PH_IDLE: begin
        if (item.op != OP_NONE) begin
          command_kind_next    = item.op;
          active_slave_next    = item.slave_id;
          held_write_byte_next = (item.op == OP_WRITE) ? item.write_data : 8'd0;
          bytes_remaining_next = 8'd0;
          length_seen_next     = 1'b0;
          poll_count_next      = 16'd0;
          phase_next           = PH_WAIT_HI;
        end
      end
      PH_WAIT_HI: begin
        if (item.ack_level) begin
          if (command_kind != OP_WRITE) begin
            res.data_valid = 1'b1;
            res.read_byte  = item.bus_in;
            if (command_kind == OP_READ) begin
              res.last = 1'b1;
            end else if (!length_seen) begin
              res.is_length        = 1'b1;
              length_seen_next     = 1'b1;
              bytes_remaining_next = item.bus_in;
              res.last             = (item.bus_in == 8'd0);
            end else begin
              bytes_remaining_next = bytes_remaining - 8'd1;
              res.last             = (bytes_remaining == 8'd1);
            end
          end
          poll_count_next = 16'd0;
          phase_next      = PH_WAIT_LO;
        end else if (poll_count == timeout_limit) begin
          res.done_res = 1'b1;
          res.status   = ST_NO_ACK;
          phase_next   = PH_IDLE;
        end else begin
          poll_count_next = poll_count + 16'd1;
        end
      end
      PH_WAIT_LO: begin
        if (!item.ack_level) begin
          poll_count_next = 16'd0;
          if (command_kind == OP_BLOCK && bytes_remaining != 8'd0) begin
            phase_next = PH_WAIT_HI;
          end else begin
            res.done_res = 1'b1;
            res.status   = ST_OK;
            phase_next   = PH_IDLE;
          end
        end else if (poll_count == timeout_limit) begin
          res.done_res = 1'b1;
          res.status   = ST_ACK_HIGH;
          phase_next   = PH_IDLE;
        end else begin
          poll_count_next = poll_count + 16'd1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    drive         = (phase_next == PH_WAIT_HI) && (command_kind_next == OP_WRITE);
    res.rw_level  = (command_kind_next == OP_WRITE);
    res.bus_drive = drive;
    res.bus_out   = drive ? held_write_byte_next : 8'd0;
    res.busy_res  = (phase_next != PH_IDLE);
    if (phase_next == PH_WAIT_HI && 32'(active_slave_next) < SLAVE_COUNT) begin
      res.req_lines = 4'd1 << active_slave_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      poll_count      <= 16'd0;
      active_slave    <= 2'd0;
      command_kind    <= OP_NONE;
      held_write_byte <= 8'd0;
      bytes_remaining <= 8'd0;
      length_seen     <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      poll_count      <= poll_count_next;
      active_slave    <= active_slave_next;
      command_kind    <= command_kind_next;
      held_write_byte <= held_write_byte_next;
      bytes_remaining <= bytes_remaining_next;
      length_seen     <= length_seen_next;
    end
  end

  a_req_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(res.req_lines))
    else $error("more than one request line raised");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    (res.status != ST_OK) |-> res.done_res)
    else $error("status set without done");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    res.data_valid |-> (command_kind != OP_WRITE) && (phase == PH_WAIT_HI))
    else $error("read byte reported outside a read wait");

  a_poll_count: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_WAIT_HI && !item.ack_level && poll_count != timeout_limit)
      |=> poll_count == 16'($past(poll_count) + 16'd1))
    else $error("poll counter did not advance");

endmodule

// ===== hw/rtl/rabm_out_stage.sv =====
`timescale 1ns / 1ps
module rabm_out_stage
  import rabm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign advance = item_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

endmodule

// ===== hw/rtl/req_ack_bus_master.sv =====
`timescale 1ns / 1ps
// bus master for a four-phase request/acknowledge byte bus. every input beat is one poll tick
// carrying the sampled ack level and bus byte plus an optional command (taken only when idle),
// and produces exactly one result beat with the line levels and any received byte. a beat is held
// in the input register, then the state update loads the result register; out_ready back-pressure
// can stall it in between. one beat per cycle is sustained while out_ready keeps the result
// register draining. timeout_limit is written through cfg_we/cfg_data, which the user must do
// only while no beats are in flight (the block does not enforce this); it resets to 25000
module req_ack_bus_master
  import rabm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [1:0]  slave_id,
  input  logic [7:0]  write_data,
  input  logic        ack_level,
  input  logic [7:0]  bus_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  req_lines,
  output logic        rw_level,
  output logic        bus_drive,
  output logic [7:0]  bus_out,
  output logic        busy_res,
  output logic        data_valid,
  output logic [7:0]  read_byte,
  output logic        is_length,
  output logic        last,
  output logic        done_res,
  output logic [1:0]  status
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t res;
  result_t out_res;

  assign in_item.op         = op;
  assign in_item.slave_id   = slave_id;
  assign in_item.write_data = write_data;
  assign in_item.ack_level  = ack_level;
  assign in_item.bus_in     = bus_in;

  rabm_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rabm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (advance),
    .item     (item),
    .res      (res)
  );

  rabm_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign req_lines  = out_res.req_lines;
  assign rw_level   = out_res.rw_level;
  assign bus_drive  = out_res.bus_drive;
  assign bus_out    = out_res.bus_out;
  assign busy_res   = out_res.busy_res;
  assign data_valid = out_res.data_valid;
  assign read_byte  = out_res.read_byte;
  assign is_length  = out_res.is_length;
  assign last       = out_res.last;
  assign done_res   = out_res.done_res;
  assign status     = out_res.status;

endmodule

// ===== sim/req_ack_bus_master_tb.sv =====
`timescale 1ns / 1ps
module req_ack_bus_master_tb;
  import rabm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_NONE;
  logic [1:0]  slave_id = '0;
  logic [7:0]  write_data = '0;
  logic        ack_level = 1'b0;
  logic [7:0]  bus_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  req_lines;
  logic        rw_level;
  logic        bus_drive;
  logic [7:0]  bus_out;
  logic        busy_res;
  logic        data_valid;
  logic [7:0]  read_byte;
  logic        is_length;
  logic        last;
  logic        done_res;
  logic [1:0]  status;

  req_ack_bus_master u_top (.*);

  // bus master shadow state
  phase_t      ph = PH_IDLE;
  logic [15:0] polls = '0;
  logic [15:0] timeout = TIMEOUT_RESET;
  logic [1:0]  slave = '0;
  logic [1:0]  kind = OP_NONE;
  logic [7:0]  wbyte = '0;
  logic [7:0]  remaining = '0;
  logic        got_len = 1'b0;

  item_t   tick_q[$];
  result_t pending_lines[$];

  int send_idle_pct = 18;
  int recv_idle_pct = 57;
  int errors = 0;
  int beats = 0;
  int cycles = 0;
  int settings = 1;
  int gen_count = 0;
  int done_count [3] = '{0, 0, 0};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t bus_tick(input item_t it);
    result_t r;
    r = '0;
    case (ph)
      PH_IDLE: begin
        if (it.op != OP_NONE) begin
          kind = it.op;
          slave = it.slave_id;
          wbyte = (it.op == OP_WRITE) ? it.write_data : 8'h00;
          remaining = '0;
          got_len = 1'b0;
          polls = '0;
          ph = PH_WAIT_HI;
        end
      end
      PH_WAIT_HI: begin
        if (it.ack_level) begin
          if (kind != OP_WRITE) begin
            r.data_valid = 1'b1;
            r.read_byte = it.bus_in;
            if (kind == OP_READ) begin
              r.last = 1'b1;
            end else if (!got_len) begin
              r.is_length = 1'b1;
              got_len = 1'b1;
              remaining = it.bus_in;
              r.last = (it.bus_in == 8'h00);
            end else begin
              remaining = remaining - 8'd1;
              r.last = (remaining == 8'h00);
            end
          end
          polls = '0;
          ph = PH_WAIT_LO;
        end else if (polls == timeout) begin
          r.done_res = 1'b1;
          r.status = ST_NO_ACK;
          ph = PH_IDLE;
        end else begin
          polls = polls + 16'd1;
        end
      end
      PH_WAIT_LO: begin
        if (!it.ack_level) begin
          polls = '0;
          if (kind == OP_BLOCK && remaining != 8'h00) begin
            ph = PH_WAIT_HI;
          end else begin
            r.done_res = 1'b1;
            r.status = ST_OK;
            ph = PH_IDLE;
          end
        end else if (polls == timeout) begin
          r.done_res = 1'b1;
          r.status = ST_ACK_HIGH;
          ph = PH_IDLE;
        end else begin
          polls = polls + 16'd1;
        end
      end
      default: ph = PH_IDLE;
    endcase
    if (ph == PH_WAIT_HI && int'(slave) < SLAVE_COUNT) r.req_lines = 4'(1 << slave);
    r.rw_level = (kind == OP_WRITE);
    r.bus_drive = (ph == PH_WAIT_HI) && (kind == OP_WRITE);
    r.bus_out = r.bus_drive ? wbyte : 8'h00;
    r.busy_res = (ph != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("no progress after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        {op, slave_id, write_data, ack_level, bus_in} <= tick_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_lines.push_back(bus_tick({op, slave_id, write_data, ack_level, bus_in}));
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {req_lines, rw_level, bus_drive, bus_out, busy_res, data_valid, read_byte,
             is_length, last, done_res, status};
      if (pending_lines.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = pending_lines.pop_front();
        check_field("req_lines", 8'(want.req_lines), 8'(got.req_lines));
        check_field("rw_level", 8'(want.rw_level), 8'(got.rw_level));
        check_field("bus_drive", 8'(want.bus_drive), 8'(got.bus_drive));
        check_field("bus_out", want.bus_out, got.bus_out);
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
        check_field("read_byte", want.read_byte, got.read_byte);
        check_field("is_length", 8'(want.is_length), 8'(got.is_length));
        check_field("last", 8'(want.last), 8'(got.last));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("status", 8'(want.status), 8'(got.status));
        beats++;
        if (want.done_res) done_count[want.status]++;
      end
    end
  end

  function automatic void push_tick(input logic [1:0] o, input logic [1:0] s,
                                    input logic [7:0] wd, input logic a, input logic [7:0] b);
    tick_q.push_back({o, s, wd, a, b});
    gen_count++;
  endfunction

  // poll beat; a command here only lands if the master is idle
  function automatic void poll(input logic a, input logic [7:0] b);
    if ($urandom_range(3) == 0) begin
      push_tick(2'($urandom), 2'($urandom), 8'($urandom), a, b);
    end else begin
      push_tick(OP_NONE, 2'($urandom), 8'($urandom), a, b);
    end
  endfunction

  function automatic void transfer(input logic [7:0] b);
    int cap;
    int gap;
    int hold;
    cap = (timeout < 3) ? int'(timeout) : 3;
    gap = $urandom_range(cap);
    if (timeout < 8 && $urandom_range(11) == 0) gap = int'(timeout) + 1;
    repeat (gap) poll(1'b0, 8'($urandom));
    poll(1'b1, b);
    hold = $urandom_range((cap > 2) ? 2 : cap);
    if (timeout < 8 && $urandom_range(11) == 0) hold = int'(timeout) + 1;
    repeat (hold) poll(1'b1, 8'($urandom));
    poll(1'b0, 8'($urandom));
  endfunction

  function automatic void transaction();
    logic [1:0] o;
    int len;
    o = 2'($urandom_range(1, 3));
    push_tick(o, 2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
    if (o == OP_BLOCK) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      transfer(8'(len));
      repeat (len) transfer(8'($urandom));
    end else begin
      transfer(8'($urandom));
    end
  endfunction

  task automatic drain();
    while (tick_q.size() != 0 || in_valid || pending_lines.size() != 0) @(negedge clk);
  endtask

  // walk the master back to idle before touching the timeout
  task automatic settle();
    drain();
    while (ph != PH_IDLE) begin
      poll(ph == PH_WAIT_HI, 8'($urandom));
      drain();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout = v;
    settings++;
  endtask

  task automatic run_segment(input logic [15:0] lim, input int n);
    int stop;
    set_timeout(lim);
    stop = gen_count + n;
    while (gen_count < stop) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3))
          push_tick(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        transaction();
      end
    end
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single read, ack level on the command beat is ignored
    push_tick(OP_READ, 2'd0, 8'h00, 1'b1, 8'h00);
    poll(1'b0, 8'h00);
    poll(1'b1, 8'hFF);
    poll(1'b1, 8'h00);
    poll(1'b0, 8'h00);
    // write
    push_tick(OP_WRITE, 2'd3, 8'hFF, 1'b0, 8'h00);
    poll(1'b1, 8'h00);
    poll(1'b0, 8'h00);
    // two byte block, request re-raised as ack falls
    push_tick(OP_BLOCK, 2'd2, 8'h00, 1'b0, 8'hFF);
    poll(1'b0, 8'h00);
    poll(1'b1, 8'd2);
    poll(1'b0, 8'h00);
    poll(1'b1, 8'hA5);
    poll(1'b0, 8'h00);
    poll(1'b1, 8'h5A);
    poll(1'b0, 8'h00);
    // empty block
    push_tick(OP_BLOCK, 2'd1, 8'hFF, 1'b1, 8'h00);
    poll(1'b1, 8'h00);
    poll(1'b0, 8'h00);
    // command while busy is dropped
    push_tick(OP_READ, 2'd1, 8'h00, 1'b0, 8'h00);
    push_tick(OP_WRITE, 2'd2, 8'h3C, 1'b1, 8'h00);
    poll(1'b0, 8'h00);
    push_tick(OP_NONE, 2'd3, 8'hFF, 1'b1, 8'hFF);
    settle();

    set_timeout(16'd0);
    // no ack
    push_tick(OP_READ, 2'd2, 8'h00, 1'b1, 8'h00);
    poll(1'b0, 8'h00);
    // ack stuck high
    push_tick(OP_WRITE, 2'd1, 8'hAA, 1'b0, 8'h00);
    poll(1'b1, 8'h00);
    poll(1'b1, 8'h00);
    // max length block cut off by a no-ack timeout
    push_tick(OP_BLOCK, 2'd3, 8'h00, 1'b0, 8'h00);
    poll(1'b1, 8'hFF);
    poll(1'b0, 8'h00);
    poll(1'b1, 8'h11);
    poll(1'b0, 8'h00);
    poll(1'b0, 8'h00);
    settle();

    run_segment(16'hFFFF, 50);
    run_segment(16'd3, 90);
    send_idle_pct = 57;
    recv_idle_pct = 18;
    run_segment(16'd1, 90);
    run_segment(16'd6, 80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(16'd2, 90);

    $display("checked %0d result beats over %0d timeout settings", beats, settings);
    $display("commands ended ok %0d, no-ack %0d, ack held high %0d",
             done_count[ST_OK], done_count[ST_NO_ACK], done_count[ST_ACK_HIGH]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
